// ----- design/mmcs_pkg.sv -----
// ----------------------------------------------------------------------------
// mmcs_pkg
// Shared types and constants for the min-max contrast stretch block.
// ----------------------------------------------------------------------------
package mmcs_pkg;

    localparam int PIX_W    = 8;
    localparam int OP_W     = 2;
    localparam int PROD_W   = 2 * PIX_W;
    localparam int CFG_IDX_W = 1;

    // Operation codes carried by an input beat.
    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd0;
    localparam logic [OP_W-1:0] OP_MEASURE = 2'd1;
    localparam logic [OP_W-1:0] OP_MAP     = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_HIGH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LOW  = 1'b1;

    // Reset values of the statistics and of the targets.
    localparam logic [PIX_W-1:0] STAT_MIN_RESET    = 8'hFF;
    localparam logic [PIX_W-1:0] STAT_MAX_RESET    = 8'h00;
    localparam logic [PIX_W-1:0] TARGET_HIGH_RESET = 8'hFF;
    localparam logic [PIX_W-1:0] TARGET_LOW_RESET  = 8'h00;

    typedef struct packed {
        logic [OP_W-1:0]  opcode;
        logic [PIX_W-1:0] pixel_value;
    } pixel_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] out_pixel;
        logic [PIX_W-1:0] seen_min;
        logic [PIX_W-1:0] seen_max;
    } result_item_t;

    // Status handed from the divider back to the sequencer.
    typedef struct packed {
        logic             done;
        logic [PIX_W-1:0] quotient;
        logic             rem_nonzero;
    } div_status_t;

endpackage

// ----- design/mmcs_div.sv -----
// ----------------------------------------------------------------------------
// mmcs_div
// Restoring divider, one quotient bit per cycle, for a quotient that is
// known to fit in PIX_W bits.
// ----------------------------------------------------------------------------
module mmcs_div
    import mmcs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [PROD_W-1:0] dividend,
    input  logic [PIX_W-1:0]  divisor,
    output div_status_t       status
);

    localparam int CNT_W = $clog2(PIX_W);

    logic [PIX_W-1:0] rem_reg, rem_next;
    logic [PIX_W-1:0] quo_reg, quo_next;
    logic [PIX_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [PIX_W:0]   trial;
    logic [PIX_W:0]   diff;
    logic             fits;

    // The upper half of the dividend is below the divisor, so it seeds the
    // partial remainder and only the lower half is shifted through.
    assign trial = {rem_reg, quo_reg[PIX_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = dividend[PROD_W-1:PIX_W];
            quo_next  = dividend[PIX_W-1:0];
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[PIX_W-1:0] : trial[PIX_W-1:0];
            quo_next = {quo_reg[PIX_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(PIX_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign status.done        = done_reg;
    assign status.quotient    = quo_reg;
    assign status.rem_nonzero = |rem_reg;

endmodule

// ----- design/min_max_contrast_stretch.sv -----
// ----------------------------------------------------------------------------
// min_max_contrast_stretch
// Two-pass min-max contrast stretch of 8-bit grey pixels with no frame store.
// ----------------------------------------------------------------------------
// The frame is streamed through twice. Measure beats fold each pixel into a
// running minimum and maximum, a clear beat returns them to 255 and 0, and
// map beats return target_low + floor((p - min) * (target_high - target_low)
// / (max - min)), with the pixel first saturated to the measured range and
// target_low returned outright when the maximum does not exceed the minimum.
// Every input beat gives exactly one result beat, which also reports the
// statistics after that beat. Clear, measure, unused opcodes and map beats on
// a flat frame reach the result register in the cycle after acceptance. Any
// other map beat passes in turn through the 8x8 multiply, the restoring
// divider (one quotient bit per cycle), a step that applies the floor
// correction and adds the low target, and a step that posts the result
// once the result register is free. The next beat can be taken once the
// sequencer has returned to idle after such a result is posted. The input
// side stalls while a map beat is in flight and while the result register
// holds a beat that the far side is stalling. The two target registers are
// written through the configuration port, which is always ready, and should
// only be changed while no beat is in flight.
// ----------------------------------------------------------------------------
module min_max_contrast_stretch
    import mmcs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PIX_W-1:0]     cfg_data,

    input  logic                 pixel_valid,
    output logic                 pixel_stall,
    input  pixel_item_t          pixel_item,

    output logic                 result_valid,
    input  logic                 result_stall,
    output result_item_t         result_item
);

    // Sequencer states.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [PIX_W-1:0] min_reg, min_next;
    logic [PIX_W-1:0] max_reg, max_next;
    logic [PIX_W-1:0] high_reg, high_next;
    logic [PIX_W-1:0] low_reg, low_next;
    logic             result_valid_reg, result_valid_next;

    // Operands of the map path; payload only, so no reset.
    logic [PIX_W-1:0] diff_reg, diff_next;
    logic [PIX_W-1:0] den_reg, den_next;
    logic [PIX_W-1:0] mag_reg, mag_next;
    logic             neg_reg, neg_next;
    logic [PIX_W-1:0] res_reg, res_next;
    result_item_t     result_item_reg, result_item_next;

    logic             accept;
    logic             out_free;
    logic             flat;
    logic [PIX_W-1:0] pix_sat;
    logic [PIX_W:0]   q_mag;
    logic             div_start;
    logic [PROD_W-1:0] product;
    div_status_t      div_status;

    assign cfg_ready = 1'b1;

    // The result register is free when empty or being emptied this cycle.
    assign out_free    = !result_valid_reg || !result_stall;
    assign pixel_stall = (state_reg != ST_IDLE) || !out_free;
    assign accept      = pixel_valid && !pixel_stall;

    // A frame whose maximum does not exceed its minimum is flat or was never
    // measured; the division is skipped.
    assign flat = (max_reg <= min_reg);

    always_comb
    begin
        if (pixel_item.pixel_value < min_reg)
        begin
            pix_sat = min_reg;
        end
        else if (pixel_item.pixel_value > max_reg)
        begin
            pix_sat = max_reg;
        end
        else
        begin
            pix_sat = pixel_item.pixel_value;
        end
    end

    // The multiply feeds the divider load directly; the divider registers it.
    assign product   = {{PIX_W{1'b0}}, diff_reg} * {{PIX_W{1'b0}}, mag_reg};
    assign div_start = (state_reg == ST_MUL);

    mmcs_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (product),
        .divisor  (den_reg),
        .status   (div_status)
    );

    // A negative scale floors towards minus infinity, so an inexact quotient
    // grows by one in magnitude. The magnitude never exceeds the target span,
    // so the sum stays inside the target range and needs no saturation.
    assign q_mag = {1'b0, div_status.quotient}
                   + {{PIX_W{1'b0}}, neg_reg && div_status.rem_nonzero};

    always_comb
    begin
        state_next        = state_reg;
        min_next          = min_reg;
        max_next          = max_reg;
        high_next         = high_reg;
        low_next          = low_reg;
        result_valid_next = result_valid_reg && result_stall;
        diff_next         = diff_reg;
        den_next          = den_reg;
        mag_next          = mag_reg;
        neg_next          = neg_reg;
        res_next          = res_reg;
        result_item_next  = result_item_reg;

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_TARGET_HIGH: high_next = cfg_data;
                CFG_TARGET_LOW:  low_next  = cfg_data;
                default:         ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (pixel_item.opcode)
                        OP_CLEAR:
                        begin
                            min_next = STAT_MIN_RESET;
                            max_next = STAT_MAX_RESET;
                        end
                        OP_MEASURE:
                        begin
                            if (pixel_item.pixel_value < min_reg)
                            begin
                                min_next = pixel_item.pixel_value;
                            end
                            if (pixel_item.pixel_value > max_reg)
                            begin
                                max_next = pixel_item.pixel_value;
                            end
                        end
                        default:
                        begin
                        end
                    endcase

                    diff_next = pix_sat - min_reg;
                    den_next  = max_reg - min_reg;
                    neg_next  = (high_reg < low_reg);
                    mag_next  = (high_reg < low_reg) ? (low_reg - high_reg)
                                                      : (high_reg - low_reg);

                    if (pixel_item.opcode == OP_MAP && !flat)
                    begin
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        result_valid_next          = 1'b1;
                        result_item_next.out_pixel = (pixel_item.opcode == OP_MAP)
                                                     ? low_reg : '0;
                        result_item_next.seen_min  = min_next;
                        result_item_next.seen_max  = max_next;
                    end
                end
            end
            ST_MUL:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_status.done)
                begin
                    res_next   = neg_reg ? (low_reg - q_mag[PIX_W-1:0])
                                         : (low_reg + q_mag[PIX_W-1:0]);
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    result_valid_next          = 1'b1;
                    result_item_next.out_pixel = res_reg;
                    result_item_next.seen_min  = min_reg;
                    result_item_next.seen_max  = max_reg;
                    state_next                 = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            min_reg          <= STAT_MIN_RESET;
            max_reg          <= STAT_MAX_RESET;
            high_reg         <= TARGET_HIGH_RESET;
            low_reg          <= TARGET_LOW_RESET;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            min_reg          <= min_next;
            max_reg          <= max_next;
            high_reg         <= high_next;
            low_reg          <= low_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg        <= diff_next;
        den_reg         <= den_next;
        mag_reg         <= mag_next;
        neg_reg         <= neg_next;
        res_reg         <= res_next;
        result_item_reg <= result_item_next;
    end

    assign result_valid = result_valid_reg;
    assign result_item  = result_item_reg;

endmodule

// ----- design/mmcs_checker.sv -----
// ----------------------------------------------------------------------------
// mmcs_checker
// Port-level checks for the contrast stretch block, bound to its top level.
// ----------------------------------------------------------------------------
module mmcs_checker
    import mmcs_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         pixel_valid,
    input logic         pixel_stall,
    input pixel_item_t  pixel_item,
    input logic         result_valid,
    input logic         result_stall,
    input result_item_t result_item
);

    logic pixel_accept;

    assign pixel_accept = pixel_valid && !pixel_stall;

    // A stalled result beat stays offered and unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result_item))
    else $error("result beat dropped or changed while stalled");

    // Beats other than map beats reach the output on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel_accept && pixel_item.opcode != OP_MAP |=> result_valid)
    else $error("non-map beat did not produce a result on the next cycle");

    // A clear leaves the statistics at their reset values.
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel_accept && pixel_item.opcode == OP_CLEAR |=>
            result_item.seen_min == STAT_MIN_RESET && result_item.seen_max == STAT_MAX_RESET)
    else $error("clear did not reset the statistics");

    // A measured pixel lies within the statistics reported for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel_accept && pixel_item.opcode == OP_MEASURE |=>
            result_item.seen_min <= $past(pixel_item.pixel_value)
            && result_item.seen_max >= $past(pixel_item.pixel_value))
    else $error("measured pixel lies outside the reported range");

endmodule

bind min_max_contrast_stretch mmcs_checker u_mmcs_checker (.*);

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the min-max contrast stretch block.
// ----------------------------------------------------------------------------
// Clear, measure, map and unused-opcode beats are pushed through the pixel
// channel. Each accepted beat is folded into a local copy of the statistics
// and the targets, and the expected result beat is queued. A free-running
// receiver compares every result beat, field by field, against the oldest
// queued expectation. The targets are only rewritten once the block has gone
// quiet. A directed part comes first, followed by randomised two-pass frames
// under several idling and stalling profiles.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import mmcs_pkg::*;

    localparam int CLK_HALF_NS  = 5;
    localparam int RESET_CYCLES = 3;
    // Well over ten times the slowest legal run of the whole stimulus.
    localparam int TIMEOUT_NS   = 3_000_000;
    // Settling time after the final drain, so that any straggler is still seen.
    localparam int SETTLE_CYCLES = 24;
    localparam int RANDOM_BEATS = 650;

    // The opcode that the block must treat as a no-op.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [PIX_W-1:0]     cfg_data;
    logic                 pixel_valid;
    logic                 pixel_stall;
    pixel_item_t          pixel_item;
    logic                 result_valid;
    logic                 result_stall;
    result_item_t         result_item;

    // Local copy of the block's statistics and targets.
    logic [PIX_W-1:0] stat_min;
    logic [PIX_W-1:0] stat_max;
    logic [PIX_W-1:0] target_high;
    logic [PIX_W-1:0] target_low;

    // Result beats that have been predicted but not yet seen. New entries
    // go in at the front and the oldest is taken from the back.
    result_item_t stretch_results_q[$];

    int unsigned sender_idle_pct;
    int unsigned receiver_stall_pct;
    int unsigned mismatch_count;

    min_max_contrast_stretch u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel_item   (pixel_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

    always #(CLK_HALF_NS) clk = ~clk;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Applies one beat to the local statistics and returns the result beat
    // that the block ought to produce for it. The map path uses exact integer
    // arithmetic and floors towards minus infinity, which matters when the
    // targets are inverted and the scale is negative.
    function automatic result_item_t contrast_stretch(pixel_item_t beat);
        result_item_t res;
        int lo;
        int hi;
        int pix;
        int den;
        int num;
        int quo;
        int val;
        res.out_pixel = '0;
        case (beat.opcode)
            OP_CLEAR:
            begin
                stat_min = STAT_MIN_RESET;
                stat_max = STAT_MAX_RESET;
            end
            OP_MEASURE:
            begin
                if (beat.pixel_value < stat_min)
                    stat_min = beat.pixel_value;
                if (beat.pixel_value > stat_max)
                    stat_max = beat.pixel_value;
            end
            OP_MAP:
            begin
                lo = int'(stat_min);
                hi = int'(stat_max);
                if (hi <= lo)
                begin
                    // A flat or unmeasured frame has no usable range.
                    res.out_pixel = target_low;
                end
                else
                begin
                    // Pixels outside the measured range saturate to its ends.
                    pix = int'(beat.pixel_value);
                    if (pix < lo)
                        pix = lo;
                    if (pix > hi)
                        pix = hi;
                    den = hi - lo;
                    num = (pix - lo) * (int'(target_high) - int'(target_low));
                    if (num >= 0)
                        quo = num / den;
                    else
                        quo = -((-num + den - 1) / den);
                    val = int'(target_low) + quo;
                    if (val < 0)
                        val = 0;
                    if (val > 255)
                        val = 255;
                    res.out_pixel = val[PIX_W-1:0];
                end
            end
            default:
            begin
                // The unused opcode leaves the statistics alone.
            end
        endcase
        res.seen_min = stat_min;
        res.seen_max = stat_max;
        return res;
    endfunction

    function automatic pixel_item_t make_beat(logic [OP_W-1:0] op, logic [PIX_W-1:0] pix);
        pixel_item_t beat;
        beat.opcode      = op;
        beat.pixel_value = pix;
        return beat;
    endfunction

    // ------------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------------

    // Samples on every rising edge, so the values seen are those that were
    // present before the edge. The stall for the next cycle is drawn here as
    // well, which keeps result_stall to one assignment per time step.
    always @(posedge clk)
    begin : check_results
        result_item_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (stretch_results_q.size() == 0)
            begin
                $error({"result beat with no expectation waiting: ",
                        "out_pixel %0d seen_min %0d seen_max %0d"},
                       result_item.out_pixel, result_item.seen_min, result_item.seen_max);
                mismatch_count++;
            end
            else
            begin
                want = stretch_results_q.pop_back();
                if (result_item.out_pixel !== want.out_pixel)
                begin
                    $error("out_pixel: expected %0d, actual %0d",
                           want.out_pixel, result_item.out_pixel);
                    mismatch_count++;
                end
                if (result_item.seen_min !== want.seen_min)
                begin
                    $error("seen_min: expected %0d, actual %0d",
                           want.seen_min, result_item.seen_min);
                    mismatch_count++;
                end
                if (result_item.seen_max !== want.seen_max)
                begin
                    $error("seen_max: expected %0d, actual %0d",
                           want.seen_max, result_item.seen_max);
                    mismatch_count++;
                end
            end
        end
        result_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Sending side
    // ------------------------------------------------------------------------

    // Offers one beat and returns at the edge where it is taken. The task is
    // always entered just after a rising edge. Idle cycles are drawn one at a
    // time, so a gap can open in front of any beat and at any stage of the
    // block's work; when no gap is drawn, valid simply stays high.
    task automatic push_pixel(pixel_item_t beat);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            pixel_valid <= 1'b0;
            @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel_item  <= beat;
        do
            @(posedge clk);
        while (pixel_stall);
        stretch_results_q.push_front(contrast_stretch(beat));
    endtask

    // Lowers valid and waits until every predicted result beat has arrived.
    // Each beat yields exactly one result, so an empty queue means the block
    // is idle.
    task automatic drain_results();
        pixel_valid <= 1'b0;
        while (stretch_results_q.size() != 0)
            @(posedge clk);
    endtask

    // Writes one target register. The beat is held until the port takes it,
    // and valid is dropped for a cycle afterwards so that back-to-back
    // writes never lower and raise it in the same step.
    task automatic write_target(logic [CFG_IDX_W-1:0] idx, logic [PIX_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_TARGET_HIGH)
            target_high = val;
        else
            target_low = val;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_targets(logic [PIX_W-1:0] high, logic [PIX_W-1:0] low);
        drain_results();
        write_target(CFG_TARGET_HIGH, high);
        write_target(CFG_TARGET_LOW, low);
    endtask

    // ------------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------------

    // Straight after reset nothing has been measured, so every map beat must
    // return the low target, and the unused opcode must change nothing.
    task automatic test_unmeasured_frame();
        push_pixel(make_beat(OP_MAP, 8'd0));
        push_pixel(make_beat(OP_MAP, 8'd255));
        push_pixel(make_beat(OP_UNUSED, 8'hAA));
    endtask

    // The full pixel range: both extremes measured, then mapped.
    task automatic test_extreme_pixels();
        push_pixel(make_beat(OP_CLEAR, 8'h55));
        push_pixel(make_beat(OP_MEASURE, 8'd0));
        push_pixel(make_beat(OP_MEASURE, 8'd255));
        push_pixel(make_beat(OP_MAP, 8'd0));
        push_pixel(make_beat(OP_MAP, 8'd255));
        push_pixel(make_beat(OP_MAP, 8'd128));
    endtask

    // A frame of one grey level has zero range and maps to the low target.
    task automatic test_flat_frame();
        push_pixel(make_beat(OP_CLEAR, 8'd0));
        push_pixel(make_beat(OP_MEASURE, 8'd100));
        push_pixel(make_beat(OP_MAP, 8'd100));
        push_pixel(make_beat(OP_MAP, 8'd7));
    endtask

    // Pixels below and above the measured range must saturate.
    task automatic test_saturated_pixels();
        push_pixel(make_beat(OP_CLEAR, 8'd0));
        push_pixel(make_beat(OP_MEASURE, 8'd50));
        push_pixel(make_beat(OP_MEASURE, 8'd200));
        push_pixel(make_beat(OP_MAP, 8'd10));
        push_pixel(make_beat(OP_MAP, 8'd250));
        push_pixel(make_beat(OP_MAP, 8'd125));
    endtask

    // High target below low target gives a negative scale, where the
    // division has to floor rather than truncate.
    task automatic test_inverted_targets();
        load_targets(8'd0, 8'd255);
        push_pixel(make_beat(OP_CLEAR, 8'd0));
        push_pixel(make_beat(OP_MEASURE, 8'd3));
        push_pixel(make_beat(OP_MEASURE, 8'd250));
        push_pixel(make_beat(OP_MAP, 8'd3));
        push_pixel(make_beat(OP_MAP, 8'd250));
        push_pixel(make_beat(OP_MAP, 8'd100));
    endtask

    // ------------------------------------------------------------------------
    // Random frames
    // ------------------------------------------------------------------------

    // Each phase picks an idling profile and a pair of targets, then streams
    // a frame twice: a measure pass over a band of grey levels followed by a
    // map pass. Now and then the clear is left out so that statistics carry
    // over, stray opcodes are mixed in, and map pixels fall outside the band.
    task automatic test_random_frames();
        int unsigned sent;
        int unsigned phase;
        int unsigned frame_len;
        int unsigned band_lo;
        int unsigned band_hi;
        logic [PIX_W-1:0] high;
        logic [PIX_W-1:0] low;
        logic [PIX_W-1:0] pix;
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_BEATS)
        begin
            drain_results();
            case (phase % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 47; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 47; end
                default: begin sender_idle_pct = 6; receiver_stall_pct = 6; end
            endcase
            case ($urandom_range(7))
                0: begin high = 8'd255; low = 8'd0;   end
                1: begin high = 8'd0;   low = 8'd255; end
                2: begin high = 8'd0;   low = 8'd0;   end
                3: begin high = 8'd255; low = 8'd255; end
                default:
                begin
                    high = PIX_W'($urandom_range(255));
                    low  = PIX_W'($urandom_range(255));
                end
            endcase
            load_targets(high, low);

            frame_len = $urandom_range(24, 4);
            if ($urandom_range(9) == 0)
            begin
                band_lo = 0;
                band_hi = 255;
            end
            else
            begin
                band_lo = $urandom_range(255);
                band_hi = $urandom_range(255, band_lo);
            end

            if ($urandom_range(7) != 0)
            begin
                push_pixel(make_beat(OP_CLEAR, PIX_W'($urandom_range(255))));
                sent++;
            end

            repeat (frame_len)
            begin
                if ($urandom_range(19) == 0)
                    push_pixel(make_beat(OP_W'($urandom_range(3)),
                                         PIX_W'($urandom_range(255))));
                else
                    push_pixel(make_beat(OP_MEASURE,
                                         PIX_W'($urandom_range(band_hi, band_lo))));
                sent++;
            end

            repeat (frame_len)
            begin
                if ($urandom_range(5) == 0)
                    pix = PIX_W'($urandom_range(255));
                else
                    pix = PIX_W'($urandom_range(band_hi, band_lo));
                if ($urandom_range(24) == 0)
                    push_pixel(make_beat(OP_UNUSED, pix));
                else
                    push_pixel(make_beat(OP_MAP, pix));
                sent++;
            end
            phase++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial
    begin
        clk                = 1'b0;
        rst_n              = 1'b0;
        cfg_valid          = 1'b0;
        cfg_index          = CFG_TARGET_HIGH;
        cfg_data           = '0;
        pixel_valid        = 1'b0;
        pixel_item         = make_beat(OP_CLEAR, 8'd0);
        result_stall       = 1'b0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        mismatch_count     = 0;
        stat_min           = STAT_MIN_RESET;
        stat_max           = STAT_MAX_RESET;
        target_high        = TARGET_HIGH_RESET;
        target_low         = TARGET_LOW_RESET;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_unmeasured_frame();
        test_extreme_pixels();
        test_flat_frame();
        test_saturated_pixels();
        test_inverted_targets();
        test_random_frames();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && stretch_results_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Guards against a hung handshake.
    initial
    begin
        #(TIMEOUT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
